FILE: sv/stk8_pkg.sv
// Shared types and constants for the 8-bit stack machine step block.
// No dependencies.
package stk8_pkg;

	localparam int MEM_DEPTH = 256;
	localparam int DATA_W    = 8;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [DATA_W-1:0] SP_RESET = 8'hff;
	localparam logic [DATA_W-1:0] ALL_ONES = 8'hff;

	localparam logic [0:0] CMD_LOAD = 1'b0;

	typedef enum logic [7:0] {
		OP_NOP  = 8'd0,
		OP_ADD  = 8'd1,
		OP_MOVA = 8'd2,
		OP_MVB  = 8'd3,
		OP_MVA  = 8'd4,
		OP_IFA  = 8'd5,
		OP_JMP  = 8'd6,
		OP_PUSH = 8'd7,
		OP_POPA = 8'd8,
		OP_POPB = 8'd9,
		OP_HLT  = 8'd10,
		OP_BNOT = 8'd11
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_OPER,
		ST_DATA,
		ST_DONE
	} seq_state_t;

endpackage

FILE: sv/stk8_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module stk8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/stack_cpu_8bit_step.sv
// Top level of the 8-bit stack machine step block: sequencer, registers, memory.
// Depends on stk8_pkg and stk8_ram.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  input   | in_valid/in_stall  | cmd, load_address, load_byte
//  output  | out_valid/out_stall| reg_a_value, reg_b_value, stack_pointer_value,
//          |                    | program_counter_value, carry_value, halt_seen
//
// A load beat passes IDLE and DONE; an instruction adds DECODE and, as its memory
// accesses need (fetch, operand or pop, data access), OPER and DATA.
// One input beat is buffered while the sequencer works, and the result waits in
// an output register, so input and output stalls are decoupled by one beat each.
// Reset clears registers (SP to ff) and byte valid bits; unwritten bytes read 0.
module stack_cpu_8bit_step
	import stk8_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [ADDR_W-1:0] load_address,
	input  logic [DATA_W-1:0] load_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] reg_a_value,
	output logic [DATA_W-1:0] reg_b_value,
	output logic [DATA_W-1:0] stack_pointer_value,
	output logic [DATA_W-1:0] program_counter_value,
	output logic              carry_value,
	output logic              halt_seen
);

	seq_state_t state_q, state_d;

	// input buffer
	logic              buf_vld_q, buf_vld_d;
	logic              buf_cmd_q;
	logic [ADDR_W-1:0] buf_addr_q;
	logic [DATA_W-1:0] buf_byte_q;

	// architectural registers
	logic [DATA_W-1:0] a_q, a_d, b_q, b_d, sp_q, sp_d, pc_q, pc_d;
	logic              c_q, c_d, halt_q, halt_d;
	opcode_t           op_q, op_d;

	logic              out_vld_d, out_load;

	// memory port
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata, rd_val;
	logic [MEM_DEPTH-1:0] mem_vld_q;
	logic              rd_vld_q;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] sp_inc;

	stk8_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// bytes never written since reset read as zero
	assign rd_val   = rd_vld_q ? mem_rdata : '0;
	assign in_stall = buf_vld_q;
	assign sum      = {1'b0, a_q} + {1'b0, b_q};
	assign sp_inc   = sp_q + 8'd1;

	always_comb begin
		state_d   = state_q;
		buf_vld_d = buf_vld_q;
		a_d       = a_q;
		b_d       = b_q;
		sp_d      = sp_q;
		pc_d      = pc_q;
		c_d       = c_q;
		halt_d    = halt_q;
		op_d      = op_q;
		mem_we    = 1'b0;
		mem_waddr = buf_addr_q;
		mem_wdata = buf_byte_q;
		mem_re    = 1'b0;
		mem_raddr = pc_q;
		out_load  = 1'b0;
		out_vld_d = out_valid && out_stall;

		if (in_valid && !in_stall) begin
			buf_vld_d = 1'b1;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (buf_vld_q) begin
					buf_vld_d = 1'b0;
					halt_d    = 1'b0;
					if (buf_cmd_q == CMD_LOAD) begin
						mem_we  = 1'b1;
						state_d = ST_DONE;
					end else begin
						mem_re  = 1'b1;
						pc_d    = pc_q + 8'd1;
						state_d = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				op_d    = opcode_t'(rd_val);
				state_d = ST_DONE;
				unique case (rd_val)
					OP_ADD: begin
						a_d = sum[DATA_W-1:0];
						c_d = sum[DATA_W];
					end
					OP_MOVA, OP_MVB, OP_MVA, OP_JMP, OP_POPA, OP_POPB: begin
						sp_d      = sp_inc;
						mem_re    = 1'b1;
						mem_raddr = sp_inc;
						state_d   = ST_OPER;
					end
					OP_IFA: begin
						if (a_q != '0) begin
							sp_d      = sp_inc;
							mem_re    = 1'b1;
							mem_raddr = sp_inc;
							state_d   = ST_OPER;
						end
					end
					OP_PUSH: begin
						mem_re  = 1'b1;
						pc_d    = pc_q + 8'd1;
						state_d = ST_OPER;
					end
					OP_HLT:  halt_d = 1'b1;
					OP_BNOT: a_d = a_q ^ ALL_ONES;
					default: ;
				endcase
			end
			ST_OPER: begin
				state_d = ST_DONE;
				unique case (op_q)
					OP_MOVA: begin
						mem_we    = 1'b1;
						mem_waddr = rd_val;
						mem_wdata = a_q;
					end
					OP_MVB, OP_MVA: begin
						mem_re    = 1'b1;
						mem_raddr = rd_val;
						state_d   = ST_DATA;
					end
					OP_IFA, OP_JMP: pc_d = rd_val;
					OP_PUSH: begin
						mem_we    = 1'b1;
						mem_waddr = sp_q;
						mem_wdata = rd_val;
						sp_d      = sp_q - 8'd1;
					end
					OP_POPA: a_d = rd_val;
					OP_POPB: b_d = rd_val;
					default: ;
				endcase
			end
			ST_DATA: begin
				if (op_q == OP_MVA) begin
					a_d = rd_val;
				end else begin
					b_d = rd_val;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!(out_valid && out_stall)) begin
					out_load  = 1'b1;
					out_vld_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			buf_vld_q <= 1'b0;
			out_valid <= 1'b0;
			a_q       <= '0;
			b_q       <= '0;
			sp_q      <= SP_RESET;
			pc_q      <= '0;
			c_q       <= 1'b0;
			halt_q    <= 1'b0;
			op_q      <= OP_NOP;
			mem_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			buf_vld_q <= buf_vld_d;
			out_valid <= out_vld_d;
			a_q       <= a_d;
			b_q       <= b_d;
			sp_q      <= sp_d;
			pc_q      <= pc_d;
			c_q       <= c_d;
			halt_q    <= halt_d;
			op_q      <= op_d;
			if (mem_we) begin
				mem_vld_q[mem_waddr] <= 1'b1;
			end
			if (mem_re) begin
				rd_vld_q <= mem_vld_q[mem_raddr];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			buf_cmd_q  <= cmd;
			buf_addr_q <= load_address;
			buf_byte_q <= load_byte;
		end
		if (out_load) begin
			reg_a_value           <= a_q;
			reg_b_value           <= b_q;
			stack_pointer_value   <= sp_q;
			program_counter_value <= pc_q;
			carry_value           <= c_q;
			halt_seen             <= halt_q;
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for stack_cpu_8bit_step: programs are loaded byte by byte and stepped,
// and every result beat is checked against a machine model kept here. Depends on stk8_pkg.
module testbench
	import stk8_pkg::*;
();

	localparam int          RANDOM_ITEMS = 900;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam int          DRAIN_CYCLES = 30;
	localparam int          HOLD_LEN     = 80;
	localparam int          PLAN         = 0;
	localparam int          LIVE         = 1;
	localparam logic        CMD_WR       = CMD_LOAD[0];
	localparam logic        CMD_EX       = !CMD_LOAD[0];

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] sp;
		logic [DATA_W-1:0] pc;
		logic              carry;
		logic              halt;
	} status_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              cmd          = CMD_WR;
	logic [ADDR_W-1:0] load_address = '0;
	logic [DATA_W-1:0] load_byte    = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [DATA_W-1:0] reg_a_value;
	logic [DATA_W-1:0] reg_b_value;
	logic [DATA_W-1:0] stack_pointer_value;
	logic [DATA_W-1:0] program_counter_value;
	logic              carry_value;
	logic              halt_seen;

	// two copies of the machine: PLAN tracks generation, LIVE tracks accepted beats
	logic [DATA_W-1:0] mach_a   [2];
	logic [DATA_W-1:0] mach_b   [2];
	logic [DATA_W-1:0] mach_sp  [2];
	logic [DATA_W-1:0] mach_pc  [2];
	logic              mach_c   [2];
	logic [DATA_W-1:0] mach_mem [2][MEM_DEPTH];

	beat_t             pending_q[$];
	status_t           want_q[$];
	logic [ADDR_W-1:0] prog_ptr;
	beat_t             drv_beat;
	logic              drv_go;
	status_t           got_st;
	status_t           want_st;
	int                sent_cnt    = 0;
	int                total_items = 1;
	int                hold_at     = 0;
	int                pause_at    = 0;
	int                hold_left   = 0;
	logic              hold_done   = 1'b0;
	logic              pause_done  = 1'b0;
	int                mism_cnt    = 0;
	int                cyc_cnt     = 0;

	stack_cpu_8bit_step dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.cmd                   (cmd),
		.load_address          (load_address),
		.load_byte             (load_byte),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.reg_a_value           (reg_a_value),
		.reg_b_value           (reg_b_value),
		.stack_pointer_value   (stack_pointer_value),
		.program_counter_value (program_counter_value),
		.carry_value           (carry_value),
		.halt_seen             (halt_seen)
	);

	function automatic void clear_machine(input int m);
		mach_a[m]  = '0;
		mach_b[m]  = '0;
		mach_sp[m] = SP_RESET;
		mach_pc[m] = '0;
		mach_c[m]  = 1'b0;
		for (int i = 0; i < MEM_DEPTH; i++)
			mach_mem[m][i] = '0;
	endfunction

	// pre-increment pop on the descending stack
	function automatic logic [DATA_W-1:0] pop_stack(input int m);
		mach_sp[m] = mach_sp[m] + 8'd1;
		return mach_mem[m][mach_sp[m]];
	endfunction

	function automatic status_t step_machine(input int m, input logic c,
			input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] op;
		logic [DATA_W-1:0] v;
		logic [DATA_W:0]   sum;
		logic              halt;
		halt = 1'b0;
		if (c == CMD_WR) begin
			mach_mem[m][addr] = data;
		end else begin
			op = mach_mem[m][mach_pc[m]];
			mach_pc[m] = mach_pc[m] + 8'd1;
			case (op)
			OP_ADD: begin
				sum       = {1'b0, mach_a[m]} + {1'b0, mach_b[m]};
				mach_c[m] = sum[DATA_W];
				mach_a[m] = sum[DATA_W-1:0];
			end
			OP_MOVA: begin
				v = pop_stack(m);
				mach_mem[m][v] = mach_a[m];
			end
			OP_MVB: begin
				v = pop_stack(m);
				mach_b[m] = mach_mem[m][v];
			end
			OP_MVA: begin
				v = pop_stack(m);
				mach_a[m] = mach_mem[m][v];
			end
			OP_IFA: begin
				if (mach_a[m] != 8'd0)
					mach_pc[m] = pop_stack(m);
			end
			OP_JMP:  mach_pc[m] = pop_stack(m);
			OP_PUSH: begin
				v = mach_mem[m][mach_pc[m]];
				mach_pc[m] = mach_pc[m] + 8'd1;
				mach_mem[m][mach_sp[m]] = v;
				mach_sp[m] = mach_sp[m] - 8'd1;
			end
			OP_POPA: mach_a[m] = pop_stack(m);
			OP_POPB: mach_b[m] = pop_stack(m);
			OP_HLT:  halt = 1'b1;
			OP_BNOT: mach_a[m] = mach_a[m] ^ ALL_ONES;
			default: ;
			endcase
		end
		return {mach_a[m], mach_b[m], mach_sp[m], mach_pc[m], mach_c[m], halt};
	endfunction

	function automatic string fmt_status(input status_t s);
		return $sformatf("a=%h b=%h sp=%h pc=%h c=%b halt=%b",
			s.a, s.b, s.sp, s.pc, s.carry, s.halt);
	endfunction

	function automatic logic chance(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic [DATA_W-1:0] rand_byte();
		return DATA_W'($urandom_range(255, 0));
	endfunction

	function automatic int stage();
		if (sent_cnt * 3 < total_items)
			return 0;
		if (sent_cnt * 3 < total_items * 2)
			return 1;
		return 2;
	endfunction

	task automatic plan_beat(input logic c, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		beat_t b;
		b.cmd  = c;
		b.addr = addr;
		b.data = data;
		pending_q.push_back(b);
		void'(step_machine(PLAN, c, addr, data));
	endtask

	task automatic plan_exec();
		plan_beat(CMD_EX, rand_byte(), rand_byte());
	endtask

	task automatic emit(input logic [DATA_W-1:0] v);
		plan_beat(CMD_WR, prog_ptr, v);
		prog_ptr = prog_ptr + 8'd1;
	endtask

	// short program written at the current PC, then stepped through
	task automatic plan_program();
		int                n_ins;
		logic [DATA_W-1:0] opc;
		n_ins    = 0;
		prog_ptr = mach_pc[PLAN];
		repeat ($urandom_range(6, 2)) begin
			if ($urandom_range(99, 0) < 8)
				opc = DATA_W'($urandom_range(255, 12));
			else
				opc = DATA_W'($urandom_range(11, 0));
			// stack consumers usually get their operand pushed first
			if (((opc >= OP_MOVA && opc <= OP_JMP) || opc == OP_POPA || opc == OP_POPB)
					&& $urandom_range(3, 0) != 0) begin
				emit(OP_PUSH);
				emit(rand_byte());
				n_ins++;
			end
			emit(opc);
			if (opc == OP_PUSH)
				emit(rand_byte());
			n_ins++;
		end
		repeat (n_ins) plan_exec();
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// driver: one beat per handshake, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				want_q.push_back(step_machine(LIVE, cmd, load_address, load_byte));
				sent_cnt = sent_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				drv_go = pending_q.size() != 0 &&
					!chance(stage() == 0 ? 35 : stage() == 1 ? 76 : 0);
				if (sent_cnt == pause_at && !pause_done) begin
					if (want_q.size() == 0)
						pause_done = 1'b1;
					else
						drv_go = 1'b0;
				end
				if (drv_go) begin
					drv_beat     = pending_q.pop_front();
					in_valid     <= 1'b1;
					cmd          <= drv_beat.cmd;
					load_address <= drv_beat.addr;
					load_byte    <= drv_beat.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result beat and drives the output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_st = {reg_a_value, reg_b_value, stack_pointer_value,
					program_counter_value, carry_value, halt_seen};
				if (want_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("unexpected result beat: %s", fmt_status(got_st));
				end else begin
					want_st = want_q.pop_front();
					if (got_st !== want_st) begin
						mism_cnt++;
						if (mism_cnt <= 10)
							$display("mismatch: expected %s, got %s",
								fmt_status(want_st), fmt_status(got_st));
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && sent_cnt >= hold_at) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= chance(stage() == 0 ? 76 : stage() == 1 ? 35 : 0);
			end
		end
	end

	initial begin
		int k;
		int target;
		clear_machine(PLAN);
		clear_machine(LIVE);

		// directed: step from reset, extreme loads, then a program covering add carry,
		// store, halt, unknown opcodes and a taken conditional jump
		plan_exec();
		plan_beat(CMD_WR, 8'hff, 8'hff);
		prog_ptr = mach_pc[PLAN];
		emit(OP_BNOT);
		emit(OP_PUSH);
		emit(8'hff);
		emit(OP_POPB);
		emit(OP_ADD);
		emit(OP_PUSH);
		emit(8'h40);
		emit(OP_MOVA);
		emit(OP_HLT);
		emit(8'd12);
		emit(8'hff);
		emit(OP_PUSH);
		emit(8'h20);
		emit(OP_IFA);
		plan_beat(CMD_WR, 8'h00, 8'h00);
		repeat (11) plan_exec();

		target = pending_q.size() + RANDOM_ITEMS;
		while (pending_q.size() < target) begin
			k = $urandom_range(99, 0);
			if (k < 75)
				plan_program();
			else if (k < 88)
				repeat ($urandom_range(4, 1))
					plan_beat(CMD_WR, rand_byte(), rand_byte());
			else
				repeat ($urandom_range(4, 1)) plan_exec();
		end
		total_items = pending_q.size();
		hold_at     = total_items * 3 / 4;
		pause_at    = total_items * 9 / 10;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (sent_cnt != total_items || want_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mism_cnt == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: stack_cpu_8bit_step.f
sv/stk8_pkg.sv
sv/stk8_ram.sv
sv/stack_cpu_8bit_step.sv
test/testbench.sv
